[rtl/efa_pkg.sv]
// ----------------------------------------------------------------------------
// efa_pkg
// Shared widths, codes, handshake structs and the constant easing tables.
// ----------------------------------------------------------------------------
`default_nettype none

package efa_pkg;

    localparam int VAL_W   = 16;              // start/end/output value width
    localparam int TIME_W  = 32;              // time counter width
    localparam int TAB_AW  = 10;              // table address bits
    localparam int TAB_N   = 1 << TAB_AW;     // last table index
    localparam int FRAC_SH = 16 - TAB_AW;     // interpolation fraction bits
    localparam int Q_W     = 17;              // Q1.16 curve width
    localparam int IDX_W   = TAB_AW + 1;
    localparam int CFG_W   = 32;
    localparam int CFG_AW  = 3;
    localparam int CMD_W   = 2;
    localparam int STEP_W  = 16;
    localparam int QUO_W   = 16;
    localparam int DCNT_W  = 4;

    localparam logic [Q_W-1:0] UNIT = Q_W'(1 << 16);

    // Register indexes of the configuration port.
    localparam logic [CFG_AW-1:0] CFG_CURVE = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_EASE  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_START = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_END   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_DUR   = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_DELAY = 3'd5;

    // Input commands. The spare code is accepted and ignored.
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    // Curve kinds.
    localparam logic [2:0] CRV_LINEAR = 3'd0;
    localparam logic [2:0] CRV_EXPO   = 3'd1;
    localparam logic [2:0] CRV_CIRC   = 3'd2;
    localparam logic [2:0] CRV_SINE   = 3'd7;

    // Ease kinds. The spare code behaves as ease in.
    localparam logic [1:0] EASE_IN     = 2'd0;
    localparam logic [1:0] EASE_MIRROR = 2'd1;
    localparam logic [1:0] EASE_INOUT  = 2'd2;
    localparam logic [1:0] EASE_SPARE  = 2'd3;

    typedef enum logic [1:0] {
        PATH_DIRECT,
        PATH_TABLE,
        PATH_CIRC,
        PATH_POW
    } t_path;

    typedef enum logic [1:0] {
        TAB_SQRT,
        TAB_COS,
        TAB_EXP
    } t_tab_sel;

    typedef struct packed {
        logic accept;
        logic check;
        logic div_step;
        logic arg;
        logic circ;
        logic pow_step;
        logic rd1;
        logic rd2;
        logic interp;
        logic post;
        logic mix1;
        logic mix2;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic  eval;
        logic  reached;
        logic  div_last;
        logic  pow_last;
        t_path path;
    } t_status;

    typedef logic [Q_W-1:0] t_tab [0:TAB_N];

    // Rounded Q16 product of two values in [0, 1].
    function automatic logic [Q_W-1:0] f_mulq(logic [Q_W-1:0] a, logic [Q_W-1:0] b);
        logic [2*Q_W-1:0] p;
        p = {{Q_W{1'b0}}, a} * {{Q_W{1'b0}}, b} + (2*Q_W)'(32768);
        return p[Q_W+15:16];
    endfunction

    // Unsigned long division by shift and subtract, for table building.
    function automatic longint unsigned f_udiv(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned f_isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        longint unsigned x;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        x = v;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [Q_W-1:0] f_q30_q16(longint s);
        longint unsigned v;
        if (s < 0) s = 0;
        v = (longint'(s) + 8192) >> 14;
        if (v > 65536) v = 65536;
        return Q_W'(v);
    endfunction

    function automatic t_tab f_build_sqrt();
        t_tab t;
        longint unsigned v;
        longint unsigned r;
        for (int i = 0; i <= TAB_N; i++) begin
            v = longint'(i) << (32 - TAB_AW);
            r = f_isqrt(v);
            if (v - r * r > r) r = r + 1;
            t[i] = Q_W'(r);
        end
        return t;
    endfunction

    function automatic t_tab f_build_cos();
        t_tab t;
        longint unsigned a;
        longint unsigned a2;
        longint unsigned term;
        longint sum;
        for (int i = 0; i <= TAB_N; i++) begin
            a    = (longint'(i) * 64'd1686629713) >> TAB_AW;
            a2   = (a * a) >> 30;
            term = 64'd1 << 30;
            sum  = 64'sd1 << 30;
            for (int k = 1; k <= 7; k++) begin
                term = f_udiv((term * a2) >> 30, longint'((2 * k - 1) * (2 * k)));
                if ((k % 2) == 1) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            t[i] = f_q30_q16(sum);
        end
        return t;
    endfunction

    function automatic t_tab f_build_exp();
        t_tab t;
        longint unsigned b;
        longint unsigned term;
        longint sum;
        for (int i = 0; i <= TAB_N; i++) begin
            b    = (longint'(i) * 64'd744261118) >> TAB_AW;
            term = 64'd1 << 30;
            sum  = 64'sd1 << 30;
            for (int k = 1; k <= 10; k++) begin
                term = f_udiv((term * b) >> 30, longint'(k));
                if ((k % 2) == 1) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            t[i] = f_q30_q16(sum);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

[rtl/eased_fade_animator.sv]
// ----------------------------------------------------------------------------
// eased_fade_animator
// Eases one value from a start to an end point over a programmed duration.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                   Payload
//   input     in         i_in_valid / o_in_ready     i_command, i_time_step
//   result    out        o_out_valid / i_out_ready   o_value, o_finished
//   config    in         i_cfg_we (no wait)          i_cfg_addr, i_cfg_data
//
// Start, stop, inactive and delay ticks give no result. A tick that
// evaluates the curve runs an update, a compare, the bit-serial progress
// divider and an argument step, then one to four power multiplies, a
// two-read table interpolation (with a circular step first for the
// circular curve) or neither, then fold, blend and output load. A tick
// that reaches the duration goes from the compare to the output load.
// Reset is synchronous and active low. A finished result waits in the
// output register; the sequencer stalls only if a second result is ready
// before the first one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module eased_fade_animator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [efa_pkg::CMD_W-1:0]     i_command,
    input  wire logic [efa_pkg::STEP_W-1:0]    i_time_step,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [efa_pkg::VAL_W-1:0]          o_value,
    output logic                               o_finished,
    input  wire logic                          i_cfg_we,
    input  wire logic [efa_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  wire logic [efa_pkg::CFG_W-1:0]     i_cfg_data
);

    efa_pkg::t_cmd    cmd;
    efa_pkg::t_status status;

    // The sequencer owns the handshakes and issues at most one command per cycle.
    efa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath holds the configuration, evaluation and output registers and all arithmetic.
    efa_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_command   (i_command),
        .i_time_step (i_time_step),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_value     (o_value),
        .o_finished  (o_finished)
    );

    // The sequencer issues at most one datapath command per cycle.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command in a cycle");

    // A new result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("result register overwritten");

    // A taken result clears valid unless another one is loaded.
    a_valid_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !cmd.load_out) |=> !o_out_valid)
        else $error("result valid held after being taken");

endmodule

`default_nettype wire

[rtl/efa_rom.sv]
// ----------------------------------------------------------------------------
// efa_rom
// Constant sqrt, cos and 2^-x tables with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module efa_rom (
    input  wire logic                         i_clk,
    input  wire efa_pkg::t_tab_sel            i_sel,
    input  wire logic [efa_pkg::IDX_W-1:0]    i_addr,
    output logic      [efa_pkg::Q_W-1:0]      o_data
);

    localparam efa_pkg::t_tab SQRT_TAB = efa_pkg::f_build_sqrt();
    localparam efa_pkg::t_tab COS_TAB  = efa_pkg::f_build_cos();
    localparam efa_pkg::t_tab EXP_TAB  = efa_pkg::f_build_exp();

    logic [efa_pkg::IDX_W-1:0] addr_c;
    logic [efa_pkg::Q_W-1:0]   r_data;

    // Addresses past the last point read the last point.
    assign addr_c = (i_addr > efa_pkg::IDX_W'(efa_pkg::TAB_N)) ?
                    efa_pkg::IDX_W'(efa_pkg::TAB_N) : i_addr;

    always_ff @(posedge i_clk) begin
        unique case (i_sel)
            efa_pkg::TAB_SQRT: r_data <= SQRT_TAB[addr_c];
            efa_pkg::TAB_EXP:  r_data <= EXP_TAB[addr_c];
            default:           r_data <= COS_TAB[addr_c];
        endcase
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

[rtl/efa_ctrl.sv]
// ----------------------------------------------------------------------------
// efa_ctrl
// Sequencer that steps the datapath through one item.
// ----------------------------------------------------------------------------
`default_nettype none

module efa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire efa_pkg::t_status  i_status,
    output efa_pkg::t_cmd          o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_CHECK  = 14'b00000000000010,
        S_DIV    = 14'b00000000000100,
        S_ARG    = 14'b00000000001000,
        S_CIRC   = 14'b00000000010000,
        S_POW    = 14'b00000000100000,
        S_RD0    = 14'b00000001000000,
        S_RD1    = 14'b00000010000000,
        S_RD2    = 14'b00000100000000,
        S_INTERP = 14'b00001000000000,
        S_POST   = 14'b00010000000000,
        S_MIX1   = 14'b00100000000000,
        S_MIX2   = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.eval) n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state = i_status.reached ? S_OUT : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = S_ARG;
            end
            S_ARG: begin
                o_cmd.arg = 1'b1;
                unique case (i_status.path)
                    efa_pkg::PATH_DIRECT: n_state = S_POST;
                    efa_pkg::PATH_TABLE:  n_state = S_RD0;
                    efa_pkg::PATH_CIRC:   n_state = S_CIRC;
                    default:              n_state = S_POW;
                endcase
            end
            S_CIRC: begin
                o_cmd.circ = 1'b1;
                n_state = S_RD0;
            end
            S_POW: begin
                o_cmd.pow_step = 1'b1;
                if (i_status.pow_last) n_state = S_POST;
            end
            S_RD0: n_state = S_RD1;
            S_RD1: begin
                o_cmd.rd1 = 1'b1;
                n_state = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd2 = 1'b1;
                n_state = S_INTERP;
            end
            S_INTERP: begin
                o_cmd.interp = 1'b1;
                n_state = S_POST;
            end
            S_POST: begin
                o_cmd.post = 1'b1;
                n_state = S_MIX1;
            end
            S_MIX1: begin
                o_cmd.mix1 = 1'b1;
                n_state = S_MIX2;
            end
            S_MIX2: begin
                o_cmd.mix2 = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[rtl/efa_dpath.sv]
// ----------------------------------------------------------------------------
// efa_dpath
// Registers, time counters, divider, curve evaluation and output blend.
// ----------------------------------------------------------------------------
`default_nettype none

module efa_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [efa_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  wire logic [efa_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic [efa_pkg::CMD_W-1:0]     i_command,
    input  wire logic [efa_pkg::STEP_W-1:0]    i_time_step,
    input  wire efa_pkg::t_cmd                 i_cmd,
    output efa_pkg::t_status                   o_status,
    output logic [efa_pkg::VAL_W-1:0]          o_value,
    output logic                               o_finished
);

    localparam int VW  = efa_pkg::VAL_W;
    localparam int TW  = efa_pkg::TIME_W;
    localparam int QW  = efa_pkg::Q_W;
    localparam int FS  = efa_pkg::FRAC_SH;
    localparam int IW  = QW + FS + 2;
    localparam int AW  = VW + QW;

    // Configuration and animation state.
    logic [2:0]    r_curve;
    logic [1:0]    r_ease;
    logic [VW-1:0] r_start, r_end;
    logic [TW-1:0] r_dur, r_delay;
    logic          r_active;
    logic [TW-1:0] r_elapsed, r_delay_el;

    // Working registers of one evaluation.
    logic [TW-1:0]                r_rem;
    logic [efa_pkg::QUO_W-1:0]    r_quo;
    logic [efa_pkg::DCNT_W-1:0]   r_dcnt;
    logic [QW-1:0]                r_x, r_y, r_targ, r_ta, r_tb, r_c;
    logic                         r_lo;
    logic [3:0]                   r_shift;
    logic [2:0]                   r_pcnt;
    logic [AW:0]                  r_acc;
    logic [VW-1:0]                r_res_val, r_out_val;
    logic                         r_res_fin, r_out_fin;

    logic [TW:0]    step_sum, delay_sum;
    logic [TW-1:0]  step_sat, delay_sat;
    logic           in_delay;
    logic [TW:0]    dbl;
    logic           dge;
    logic [QW-1:0]  x_c, y_clamp, tr_c, c_c, c_raw, yh;
    logic           lo_c;
    logic [19:0]    k_c;
    logic [efa_pkg::IDX_W-1:0] idx_c, idx2_c;
    logic [FS-1:0]  fr_c;
    logic [IW-1:0]  interp_c;
    logic [AW+1:0]  mix_c;
    efa_pkg::t_tab_sel tab_sel;
    logic [QW-1:0]  rom_q;

    // Saturating time additions.
    assign step_sum  = {1'b0, r_elapsed} + (TW+1)'(i_time_step);
    assign step_sat  = step_sum[TW] ? {TW{1'b1}} : step_sum[TW-1:0];
    assign delay_sum = {1'b0, r_delay_el} + (TW+1)'(i_time_step);
    assign delay_sat = delay_sum[TW] ? {TW{1'b1}} : delay_sum[TW-1:0];
    assign in_delay  = r_delay_el < r_delay;

    // One quotient bit per cycle.
    assign dbl = {r_rem, 1'b0};
    assign dge = dbl >= {1'b0, r_dur};

    // Curve argument from progress and ease kind.
    always_comb begin
        lo_c = ~r_quo[efa_pkg::QUO_W-1];
        if (r_ease == efa_pkg::EASE_MIRROR) begin
            x_c = efa_pkg::UNIT - QW'(r_quo);
        end else if (r_ease == efa_pkg::EASE_INOUT) begin
            if (lo_c) x_c = {r_quo, 1'b0};
            else x_c = QW'((efa_pkg::UNIT - QW'(r_quo)) << 1);
        end else begin
            x_c = QW'(r_quo);
        end
    end

    assign k_c = 20'(efa_pkg::UNIT - x_c) * 20'd10;

    // Table addressing and interpolation.
    assign idx_c  = r_targ[16] ? efa_pkg::IDX_W'(efa_pkg::TAB_N)
                               : efa_pkg::IDX_W'(r_targ[15:FS]);
    assign fr_c   = r_targ[16] ? '0 : r_targ[FS-1:0];
    assign idx2_c = (fr_c == '0) ? idx_c : idx_c + 1'b1;
    assign interp_c = IW'(r_ta) * IW'((1 << FS) - int'(fr_c))
                    + IW'(r_tb) * IW'(fr_c) + IW'(1 << (FS - 1));
    assign tr_c = QW'(interp_c >> FS);

    always_comb begin
        unique case (r_curve)
            efa_pkg::CRV_EXPO: tab_sel = efa_pkg::TAB_EXP;
            efa_pkg::CRV_CIRC: tab_sel = efa_pkg::TAB_SQRT;
            default:           tab_sel = efa_pkg::TAB_COS;
        endcase
    end

    efa_rom u_rom (
        .i_clk  (i_clk),
        .i_sel  (tab_sel),
        .i_addr (i_cmd.rd1 ? idx2_c : idx_c),
        .o_data (rom_q)
    );

    assign y_clamp = (r_y > efa_pkg::UNIT) ? efa_pkg::UNIT : r_y;

    // Fold the ease-in curve into out and in-out.
    always_comb begin
        yh = r_y >> 1;
        if (r_ease == efa_pkg::EASE_MIRROR) c_raw = efa_pkg::UNIT - r_y;
        else if (r_ease == efa_pkg::EASE_INOUT) c_raw = r_lo ? yh : efa_pkg::UNIT - yh;
        else c_raw = r_y;
        c_c = (c_raw > efa_pkg::UNIT) ? efa_pkg::UNIT : c_raw;
    end

    assign mix_c = {1'b0, r_acc} + (AW+2)'(r_end) * (AW+2)'(r_c) + (AW+2)'(32768);

    always_comb begin
        o_status.eval     = (i_command == efa_pkg::CMD_TICK) && r_active && !in_delay;
        o_status.reached  = r_elapsed >= r_dur;
        o_status.div_last = r_dcnt == {efa_pkg::DCNT_W{1'b1}};
        o_status.pow_last = r_pcnt == 3'd1;
        unique case (r_curve)
            efa_pkg::CRV_LINEAR: o_status.path = efa_pkg::PATH_DIRECT;
            efa_pkg::CRV_EXPO:   o_status.path = (x_c == '0) ? efa_pkg::PATH_DIRECT
                                                             : efa_pkg::PATH_TABLE;
            efa_pkg::CRV_CIRC:   o_status.path = efa_pkg::PATH_CIRC;
            efa_pkg::CRV_SINE:   o_status.path = efa_pkg::PATH_TABLE;
            default:             o_status.path = efa_pkg::PATH_POW;
        endcase
    end

    // Control state: configuration, activity and time counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve    <= '0;
            r_ease     <= '0;
            r_start    <= '0;
            r_end      <= VW'(65535);
            r_dur      <= TW'(1000);
            r_delay    <= '0;
            r_active   <= 1'b0;
            r_elapsed  <= '0;
            r_delay_el <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    efa_pkg::CFG_CURVE: r_curve <= i_cfg_data[2:0];
                    efa_pkg::CFG_EASE:  r_ease  <= i_cfg_data[1:0];
                    efa_pkg::CFG_START: begin
                        r_start   <= i_cfg_data[VW-1:0];
                        r_elapsed <= '0;
                    end
                    efa_pkg::CFG_END: begin
                        r_end     <= i_cfg_data[VW-1:0];
                        r_elapsed <= '0;
                    end
                    efa_pkg::CFG_DUR: begin
                        r_dur     <= TW'(i_cfg_data);
                        r_elapsed <= '0;
                    end
                    efa_pkg::CFG_DELAY: r_delay <= TW'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                unique case (i_command)
                    efa_pkg::CMD_START: begin
                        r_elapsed  <= '0;
                        r_delay_el <= '0;
                        r_active   <= 1'b1;
                    end
                    efa_pkg::CMD_STOP: r_active <= 1'b0;
                    efa_pkg::CMD_TICK: begin
                        if (r_active) begin
                            if (in_delay) r_delay_el <= delay_sat;
                            else r_elapsed <= step_sat;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Evaluation registers (no reset needed).
    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_res_val <= r_end;
            r_res_fin <= 1'b1;
            r_rem     <= r_elapsed;
            r_quo     <= '0;
            r_dcnt    <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= dge ? TW'(dbl - {1'b0, r_dur}) : dbl[TW-1:0];
            r_quo  <= {r_quo[efa_pkg::QUO_W-2:0], dge};
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.arg) begin
            r_x  <= x_c;
            r_lo <= lo_c;
            unique case (r_curve)
                efa_pkg::CRV_LINEAR: r_y <= x_c;
                efa_pkg::CRV_EXPO: begin
                    r_y     <= '0;
                    r_targ  <= {1'b0, k_c[15:0]};
                    r_shift <= k_c[19:16];
                end
                efa_pkg::CRV_CIRC: r_y <= efa_pkg::f_mulq(x_c, x_c);
                efa_pkg::CRV_SINE: r_targ <= x_c;
                default: begin
                    r_y    <= x_c;
                    r_pcnt <= r_curve - 3'd2;
                end
            endcase
        end
        if (i_cmd.circ) r_targ <= efa_pkg::UNIT - y_clamp;
        if (i_cmd.pow_step) begin
            r_y    <= efa_pkg::f_mulq(r_y, r_x);
            r_pcnt <= r_pcnt - 3'd1;
        end
        if (i_cmd.rd1) r_ta <= rom_q;
        if (i_cmd.rd2) r_tb <= rom_q;
        if (i_cmd.interp) begin
            if (r_curve == efa_pkg::CRV_EXPO) r_y <= tr_c >> r_shift;
            else r_y <= efa_pkg::UNIT - tr_c;
        end
        if (i_cmd.post) r_c <= c_c;
        if (i_cmd.mix1) r_acc <= (AW+1)'(r_start) * (AW+1)'(efa_pkg::UNIT - r_c);
        if (i_cmd.mix2) begin
            r_res_val <= mix_c[VW+15:16];
            r_res_fin <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out_val <= r_res_val;
            r_out_fin <= r_res_fin;
        end
    end

    assign o_value    = r_out_val;
    assign o_finished = r_out_fin;

endmodule

`default_nettype wire
